FILE: src/glu_pkg.sv
package glu_pkg;

	localparam int OpW  = 31;
	localparam int MulW = 62;
	localparam int AluW = MulW + 1;
	localparam int CntW = 5;

	localparam logic [CntW-1:0] LastStep = CntW'(OpW - 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_ALIGN  = 6'b000010,
		ST_REDUCE = 6'b000100,
		ST_DIVIDE = 6'b001000,
		ST_MULT   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	typedef struct packed {
		logic [MulW-1:0] a;
		logic [MulW-1:0] b;
		logic            sub;
	} alu_req_t;

	typedef struct packed {
		logic [OpW-1:0]  divisor;
		logic [MulW-1:0] multiple;
		logic            both_zero;
	} result_t;

endpackage

FILE: src/glu_alu.sv
module glu_alu (
	input  glu_pkg::alu_req_t              req,
	output logic [glu_pkg::AluW-1:0]       sum
);
	import glu_pkg::*;

	logic [MulW-1:0] b_eff;

	// For a subtraction the top bit of the sum is set when a >= b.
	assign b_eff = req.sub ? ~req.b : req.b;
	assign sum   = {1'b0, req.a} + {1'b0, b_eff} + AluW'(req.sub);

endmodule

FILE: src/glu_out_reg.sv
module glu_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	output logic              res_ready,
	input  glu_pkg::result_t  res,
	output logic              out_valid,
	input  logic              out_ready,
	output glu_pkg::result_t  out_res
);
	import glu_pkg::*;

	logic    valid_q;
	result_t data_q;
	logic    take;

	assign res_ready = !valid_q || out_ready;
	assign take      = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = data_q;

endmodule

FILE: src/glu_core.sv
module glu_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [glu_pkg::OpW-1:0]    first_value,
	input  logic [glu_pkg::OpW-1:0]    second_value,
	output logic                       res_valid,
	input  logic                       res_ready,
	output glu_pkg::result_t           res
);
	import glu_pkg::*;

	state_t          state_q;
	logic [OpW-1:0]  a_q;
	logic [OpW-1:0]  b_q;
	logic [OpW-1:0]  x_q;
	logic [OpW-1:0]  y_q;
	logic [OpW-1:0]  g_q;
	logic [OpW-1:0]  rem_q;
	logic [OpW-1:0]  div_q;
	logic [MulW-1:0] acc_q;
	logic [MulW-1:0] bsh_q;
	logic [CntW-1:0] k_q;
	logic [CntW-1:0] cnt_q;
	logic            zero_q;

	alu_req_t        req;
	logic [AluW-1:0] sum;
	logic [OpW:0]    rem_shift;
	logic            ge;
	logic            equal;
	logic            accept;
	logic            any_zero;

	glu_alu u_alu (
		.req (req),
		.sum (sum)
	);

	assign rem_shift = {rem_q, x_q[OpW-1]};
	assign ge        = sum[AluW-1];
	assign equal     = (sum[MulW-1:0] == '0);
	assign accept    = in_valid && in_ready;
	assign any_zero  = (first_value == '0) || (second_value == '0);

	always_comb begin
		req = '0;
		unique case (state_q)
			ST_REDUCE: begin
				req.a   = MulW'(x_q);
				req.b   = MulW'(y_q);
				req.sub = 1'b1;
			end
			ST_DIVIDE: begin
				req.a   = MulW'(rem_shift);
				req.b   = MulW'(g_q);
				req.sub = 1'b1;
			end
			ST_MULT: begin
				req.a   = acc_q;
				req.b   = bsh_q;
				req.sub = 1'b0;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= any_zero ? ST_DONE : ST_ALIGN;
					end
				end
				ST_ALIGN: begin
					if (x_q[0] || y_q[0]) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (x_q[0] && y_q[0] && equal) begin
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (cnt_q == LastStep) begin
						state_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					if (cnt_q == LastStep) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					a_q    <= first_value;
					b_q    <= second_value;
					x_q    <= first_value;
					y_q    <= second_value;
					k_q    <= '0;
					div_q  <= first_value | second_value;
					acc_q  <= '0;
					zero_q <= (first_value == '0) && (second_value == '0);
				end
			end
			ST_ALIGN: begin
				// Common factors of two are counted and restored at the end.
				if (!(x_q[0] || y_q[0])) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end
			end
			ST_REDUCE: begin
				if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (equal) begin
					g_q   <= x_q << k_q;
					x_q   <= a_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (ge) begin
					x_q <= sum[OpW-1:0];
				end else begin
					// Swap so that the next subtraction leaves a positive even value.
					x_q <= y_q;
					y_q <= x_q;
				end
			end
			ST_DIVIDE: begin
				// Restoring division of the first operand by the GCD; the quotient
				// shifts into x_q as the dividend shifts out.
				rem_q <= ge ? sum[OpW-1:0] : rem_shift[OpW-1:0];
				x_q   <= {x_q[OpW-2:0], ge};
				if (cnt_q == LastStep) begin
					cnt_q <= '0;
					acc_q <= '0;
					bsh_q <= MulW'(b_q);
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_MULT: begin
				if (x_q[0]) begin
					acc_q <= sum[MulW-1:0];
				end
				bsh_q <= bsh_q << 1;
				x_q   <= x_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastStep) begin
					div_q  <= g_q;
					zero_q <= 1'b0;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign res_valid     = (state_q == ST_DONE);
	assign res.divisor   = div_q;
	assign res.multiple  = acc_q;
	assign res.both_zero = zero_q;

endmodule

FILE: src/gcd_lcm_unit.sv
// Channel  Signals                                   Direction
// input    in_valid, in_ready, first_value,          operands in
//          second_value
// output   out_valid, out_ready, divisor, multiple,  GCD, exact LCM and
//          both_zero                                 both-zero flag out
//
// One transaction at a time. A zero operand goes straight to the done state;
// otherwise binary GCD steps in the shared adder come first, then a 31-step
// restoring division and a 31-step shift-add multiply.
// The single 62-bit add/subtract unit sets the pace of every step.
// Reset clears the sequencer and the output valid; data registers are not reset.
// The output register lets a new transaction start while a result awaits out_ready.
module gcd_lcm_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [glu_pkg::OpW-1:0]    first_value,
	input  logic [glu_pkg::OpW-1:0]    second_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [glu_pkg::OpW-1:0]    divisor,
	output logic [glu_pkg::MulW-1:0]   multiple,
	output logic                       both_zero
);
	import glu_pkg::*;

	logic    res_valid;
	logic    res_ready;
	result_t res;
	result_t out_res;

	glu_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_value  (first_value),
		.second_value (second_value),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	glu_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign divisor   = out_res.divisor;
	assign multiple  = out_res.multiple;
	assign both_zero = out_res.both_zero;

endmodule
